@@ hw/rtl/text_terminal_char_buffer_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the text terminal character buffer
// Shared assertion forms, disabled while the reset is low; the short form uses clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef TEXT_TERMINAL_CHAR_BUFFER_TOP_DEFINES_SVH
`define TEXT_TERMINAL_CHAR_BUFFER_TOP_DEFINES_SVH

// General form: explicit clock and active-low reset.
`define TTCB_ASSERT_CLK(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
		else $error("ttcb assertion failed");

// Short form on the block's own clock and reset.
`define TTCB_ASSERT(lbl, prop) \
	`TTCB_ASSERT_CLK(lbl, clk, arst_n, prop)

`endif

@@ hw/rtl/ttcb_pkg.sv @@
// ----------------------------------------------------------------------------
// ttcb_pkg
// Geometry, character codes, command encoding and helper functions.
// ----------------------------------------------------------------------------
package ttcb_pkg;

	localparam int COLS     = 21;
	localparam int ROWS     = 8;
	localparam int COL_W    = 5;
	localparam int ROW_W    = 3;
	localparam int CHAR_W   = 8;
	localparam int FUNC_W   = 2;
	localparam int MASK_W   = 8;
	localparam int CELL_NUM = ROWS * COLS;
	localparam int ADDR_W   = $clog2(CELL_NUM);
	localparam int QDEPTH   = 2;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;
	localparam logic [CHAR_W-1:0] CH_BS    = 8'h7f;
	localparam logic [CHAR_W-1:0] CH_NL    = 8'h0a;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;

	localparam logic [FUNC_W-1:0] FN_PUT     = 2'd0;
	localparam logic [FUNC_W-1:0] FN_READ    = 2'd1;
	localparam logic [FUNC_W-1:0] FN_CLEAR   = 2'd2;
	localparam logic [FUNC_W-1:0] FN_COLLECT = 2'd3;

	typedef logic [2:0] op_t;
	localparam op_t OP_WRITE   = 3'd0;
	localparam op_t OP_BACK    = 3'd1;
	localparam op_t OP_NEWLINE = 3'd2;
	localparam op_t OP_RETURN  = 3'd3;
	localparam op_t OP_READ    = 3'd4;
	localparam op_t OP_CLEAR   = 3'd5;
	localparam op_t OP_COLLECT = 3'd6;

	typedef struct packed {
		op_t               op;
		logic [CHAR_W-1:0] ch;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic              in_range;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	// Screen line to physical line, given the line that currently sits on top.
	function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] top,
	                                              input logic [ROW_W-1:0] r);
		logic [ROW_W:0] sum;
		sum = {1'b0, top} + {1'b0, r};
		if (sum >= (ROW_W + 1)'(ROWS)) begin
			sum = sum - (ROW_W + 1)'(ROWS);
		end
		return sum[ROW_W-1:0];
	endfunction

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
	                                               input logic [COL_W-1:0] c);
		logic [ADDR_W-1:0] base;
		base = ADDR_W'(prow) * ADDR_W'(COLS);
		return base + ADDR_W'(c);
	endfunction

	function automatic logic [ROWS-1:0] line_bit(input logic [ROW_W-1:0] r);
		return ROWS'(1) << r;
	endfunction

endpackage

@@ hw/rtl/ttcb_front.sv @@
// ----------------------------------------------------------------------------
// ttcb_front
// Takes requests and decodes them into back-end commands.
// ----------------------------------------------------------------------------
module ttcb_front import ttcb_pkg::*; (
	input  logic              start,
	input  q_stat_t           q_stat,
	input  logic [FUNC_W-1:0] func,
	input  logic [CHAR_W-1:0] ch,
	input  logic [ROW_W-1:0]  row,
	input  logic [COL_W-1:0]  col,
	output logic              push,
	output cmd_t              cmd
);

	assign push = start && !q_stat.full;

	always_comb begin
		cmd.ch       = ch;
		cmd.row      = row;
		cmd.col      = col;
		cmd.in_range = (int'(row) < ROWS) && (int'(col) < COLS);
		unique case (func)
			FN_PUT: begin
				priority if (ch == CH_BS) begin
					cmd.op = OP_BACK;
				end else if (ch == CH_NL) begin
					cmd.op = OP_NEWLINE;
				end else if (ch == CH_CR) begin
					cmd.op = OP_RETURN;
				end else begin
					cmd.op = OP_WRITE;
				end
			end
			FN_READ:    cmd.op = OP_READ;
			FN_CLEAR:   cmd.op = OP_CLEAR;
			FN_COLLECT: cmd.op = OP_COLLECT;
			default:    cmd.op = OP_COLLECT;
		endcase
	end

endmodule

@@ hw/rtl/ttcb_queue.sv @@
// ----------------------------------------------------------------------------
// ttcb_queue
// Small command queue between the decoder and the screen engine.
// ----------------------------------------------------------------------------
module ttcb_queue import ttcb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    cmd_in,
	input  logic    pop,
	output cmd_t    cmd_out,
	output q_stat_t q_stat
);

	cmd_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign q_stat.empty = (count_q == '0);
	assign q_stat.full  = (count_q == QCNT_W'(QDEPTH));
	assign cmd_out      = entry_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/ttcb_back.sv @@
// ----------------------------------------------------------------------------
// ttcb_back
// Screen engine: cursor, scroll pointer, dirty mask and the cell memory.
// ----------------------------------------------------------------------------
module ttcb_back import ttcb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  q_stat_t           q_stat,
	input  cmd_t              cmd,
	output logic              pop,
	output logic              done,
	output logic [COL_W-1:0]  cur_col,
	output logic [ROW_W-1:0]  cur_row,
	output logic [CHAR_W-1:0] cell_char,
	output logic [MASK_W-1:0] dirty_mask,
	output logic              scrolled
);

	localparam logic BK_IDLE = 1'b0;
	localparam logic BK_READ = 1'b1;

	logic [CHAR_W-1:0] mem [CELL_NUM];
	// A cell whose bit is clear reads as a blank.
	logic [ROWS-1:0][COLS-1:0] vld_q;

	logic              state_q;
	logic [COL_W-1:0]  cx_q;
	logic [ROW_W-1:0]  cy_q;
	logic [ROW_W-1:0]  top_q;
	logic [ROWS-1:0]   dirty_q;

	logic [CHAR_W-1:0] rd_data_s1;
	logic              rd_vld_s1;
	logic              rd_range_s1;

	logic              done_q;
	logic [COL_W-1:0]  cur_col_q;
	logic [ROW_W-1:0]  cur_row_q;
	logic [CHAR_W-1:0] cell_char_q;
	logic [MASK_W-1:0] dirty_mask_q;
	logic              scrolled_q;

	logic              emit;
	logic              do_lf;
	logic              scr;
	logic              rd_issue;
	logic [COL_W-1:0]  nx;
	logic [ROW_W-1:0]  ny;
	logic [ROW_W-1:0]  ntop;
	logic [ROWS-1:0]   ndirty;
	logic [ROWS-1:0]   mask_out;
	logic              we;
	logic              clr_cell;
	logic              clr_row;
	logic              clr_all;
	logic [ROW_W-1:0]  crow;
	logic [COL_W-1:0]  ccol;
	logic [ROW_W-1:0]  rrow;
	logic [COL_W-1:0]  rcol;

	assign pop = !q_stat.empty && (state_q == BK_IDLE);

	always_comb begin
		emit     = 1'b0;
		do_lf    = 1'b0;
		scr      = 1'b0;
		rd_issue = 1'b0;
		nx       = cx_q;
		ny       = cy_q;
		ntop     = top_q;
		ndirty   = dirty_q;
		we       = 1'b0;
		clr_cell = 1'b0;
		clr_row  = 1'b0;
		clr_all  = 1'b0;
		crow     = phys_row(top_q, cy_q);
		ccol     = cx_q;
		rrow     = cmd.in_range ? phys_row(top_q, cmd.row) : '0;
		rcol     = cmd.in_range ? cmd.col : '0;
		if (pop) begin
			unique case (cmd.op)
				OP_WRITE: begin
					emit   = 1'b1;
					we     = 1'b1;
					ndirty = dirty_q | line_bit(cy_q);
					if (cx_q == COL_W'(COLS - 1)) begin
						do_lf = 1'b1;
					end else begin
						nx = cx_q + 1'b1;
					end
				end
				OP_BACK: begin
					emit = 1'b1;
					if (!(cx_q == '0 && cy_q == '0)) begin
						if (cx_q == '0) begin
							ny = cy_q - 1'b1;
							nx = COL_W'(COLS - 1);
						end else begin
							nx = cx_q - 1'b1;
						end
						clr_cell = 1'b1;
						crow     = phys_row(top_q, ny);
						ccol     = nx;
						ndirty   = dirty_q | line_bit(ny);
					end
				end
				OP_NEWLINE: begin
					emit  = 1'b1;
					do_lf = 1'b1;
				end
				OP_RETURN: begin
					emit   = 1'b1;
					nx     = '0;
					ndirty = dirty_q | line_bit(cy_q);
				end
				OP_READ: begin
					rd_issue = 1'b1;
				end
				OP_CLEAR: begin
					emit    = 1'b1;
					clr_all = 1'b1;
					ntop    = '0;
					nx      = '0;
					ny      = '0;
				end
				OP_COLLECT: begin
					emit   = 1'b1;
					ndirty = '0;
				end
				default: begin
					emit = 1'b1;
				end
			endcase
		end
		if (do_lf) begin
			nx = '0;
			if (cy_q == ROW_W'(ROWS - 1)) begin
				clr_row = 1'b1;
				ntop    = (top_q == ROW_W'(ROWS - 1)) ? '0 : top_q + 1'b1;
				ndirty  = '1;
				scr     = 1'b1;
			end else begin
				ny = cy_q + 1'b1;
			end
		end
		mask_out = (pop && cmd.op == OP_COLLECT) ? dirty_q : ndirty;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[cell_addr(crow, ccol)] <= cmd.ch;
		end
		if (rd_issue) begin
			rd_data_s1  <= mem[cell_addr(rrow, rcol)];
			rd_vld_s1   <= vld_q[rrow][rcol];
			rd_range_s1 <= cmd.in_range;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			state_q <= BK_IDLE;
			cx_q    <= '0;
			cy_q    <= '0;
			top_q   <= '0;
			dirty_q <= '0;
			done_q  <= 1'b0;
		end else begin
			if (clr_all) begin
				vld_q <= '0;
			end else begin
				if (clr_row) begin
					vld_q[top_q] <= '0;
				end
				if (we) begin
					vld_q[crow][ccol] <= 1'b1;
				end
				if (clr_cell) begin
					vld_q[crow][ccol] <= 1'b0;
				end
			end
			cx_q    <= nx;
			cy_q    <= ny;
			top_q   <= ntop;
			dirty_q <= ndirty;
			state_q <= rd_issue ? BK_READ : BK_IDLE;
			done_q  <= emit || (state_q == BK_READ);
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			cur_col_q    <= nx;
			cur_row_q    <= ny;
			cell_char_q  <= '0;
			dirty_mask_q <= MASK_W'(mask_out);
			scrolled_q   <= scr;
		end else if (state_q == BK_READ) begin
			cur_col_q    <= cx_q;
			cur_row_q    <= cy_q;
			cell_char_q  <= !rd_range_s1 ? '0 : (rd_vld_s1 ? rd_data_s1 : CH_BLANK);
			dirty_mask_q <= MASK_W'(dirty_q);
			scrolled_q   <= 1'b0;
		end
	end

	assign done       = done_q;
	assign cur_col    = cur_col_q;
	assign cur_row    = cur_row_q;
	assign cell_char  = cell_char_q;
	assign dirty_mask = dirty_mask_q;
	assign scrolled   = scrolled_q;

endmodule

@@ hw/rtl/text_terminal_char_buffer_top.sv @@
// ----------------------------------------------------------------------------
// text_terminal_char_buffer_top
// Text screen of 8 lines by 21 columns with cursor and per-line dirty mask.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge where start is high and busy is low.
// func selects the operation: put a byte (with backspace, newline and
// carriage return handling), read a cell at row/col, clear the screen, or
// collect and clear the dirty mask. Every request gives exactly one result,
// shown for a single cycle with done high; the receiver cannot stall it.
// The decoder writes requests into a two-entry queue, and busy is high
// only while that queue is full.
// With the engine idle, a non-read request passes the queue entry and the
// done register before done rises; a read also passes the registered cell
// memory port first.
// The screen engine retires one command per cycle while no read is in
// flight, and takes no new command while a read waits for the cell memory,
// so a scroll, which only clears the valid bits of one line, costs no extra time.
// Reset clears the cursor, the scroll pointer, the dirty mask, the queue
// and all cell valid bits, so every cell reads as a space right away.
// ----------------------------------------------------------------------------
module text_terminal_char_buffer_top import ttcb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [FUNC_W-1:0] func,
	input  logic [CHAR_W-1:0] ch,
	input  logic [ROW_W-1:0]  row,
	input  logic [COL_W-1:0]  col,
	output logic              done,
	output logic [COL_W-1:0]  cur_col,
	output logic [ROW_W-1:0]  cur_row,
	output logic [CHAR_W-1:0] cell_char,
	output logic [MASK_W-1:0] dirty_mask,
	output logic              scrolled
);

	q_stat_t q_stat;
	logic    push;
	logic    pop;
	cmd_t    cmd_in;
	cmd_t    cmd_out;

	// Backpressure comes only from the queue.
	assign busy = q_stat.full;

	ttcb_front u_front (
		.start  (start),
		.q_stat (q_stat),
		.func   (func),
		.ch     (ch),
		.row    (row),
		.col    (col),
		.push   (push),
		.cmd    (cmd_in)
	);

	ttcb_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.cmd_in  (cmd_in),
		.pop     (pop),
		.cmd_out (cmd_out),
		.q_stat  (q_stat)
	);

	// The engine pops only when it has a command and no read is in flight.
	ttcb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_stat     (q_stat),
		.cmd        (cmd_out),
		.pop        (pop),
		.done       (done),
		.cur_col    (cur_col),
		.cur_row    (cur_row),
		.cell_char  (cell_char),
		.dirty_mask (dirty_mask),
		.scrolled   (scrolled)
	);

endmodule

@@ hw/rtl/ttcb_checker.sv @@
// ----------------------------------------------------------------------------
// ttcb_checker
// Port-level checks on the character buffer, bound to the top level.
// ----------------------------------------------------------------------------
`include "text_terminal_char_buffer_top_defines.svh"

module ttcb_checker import ttcb_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic [COL_W-1:0]  cur_col,
	input logic [ROW_W-1:0]  cur_row,
	input logic [MASK_W-1:0] dirty_mask,
	input logic              scrolled
);

	// The cursor column always stays on the screen.
	`TTCB_ASSERT(a_col_on_screen, done |-> (int'(cur_col) < COLS))
	// A scroll leaves the cursor at the start of the bottom line.
	`TTCB_ASSERT(a_scroll_cursor, done && scrolled |-> (cur_col == '0 && cur_row == ROW_W'(ROWS - 1)))
	// A scroll marks every line dirty.
	`TTCB_ASSERT(a_scroll_dirty, done && scrolled |-> (dirty_mask == MASK_W'({ROWS{1'b1}})))
	// The queue can only fill up on a new request.
	`TTCB_ASSERT(a_busy_cause, $rose(busy) |-> $past(start))

endmodule

bind text_terminal_char_buffer_top ttcb_checker u_ttcb_checker (.*);
